// ===== src/mwl_pkg.sv =====
package mwl_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TARGET_W = 26;
   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

   typedef struct packed {
      logic accept;
      logic pop_read;
      logic pop_apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic qualify;
      logic last;
      logic rsp_free;
   } sts_type;

endpackage

// ===== src/mwl_ram.sv =====
module mwl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mwl_ctrl.sv =====
module mwl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mwl_pkg::sts_type  sts,
   output mwl_pkg::cmd_type  cmd
);
   import mwl_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_POP   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.qualify) begin
               cmd.pop_read = 1'b1;
               state_in     = S_POP;
            end else if (sts.last) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            cmd.pop_apply = 1'b1;
            state_in      = S_CHECK;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== src/mwl_datapath.sv =====
module mwl_datapath #(
   parameter int MAX_LEN = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mwl_pkg::cmd_type                      cmd,
   output mwl_pkg::sts_type                      sts,
   input  logic [mwl_pkg::SAMPLE_W-1:0]          req_sample_value,
   input  logic                                  req_is_last,
   input  logic                                  csr_wr_en,
   input  logic [mwl_pkg::TARGET_W-1:0]          csr_wr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [$clog2(MAX_LEN+1)-1:0]          rsp_shortest_length,
   output logic                                  rsp_overflowed
);
   import mwl_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = SAMPLE_W + IDX_W;
   localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEN);

   logic [TARGET_W-1:0] target_ff;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    items_ff, items_in;
   logic [CNT_W-1:0]    best_ff, best_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                overflow_ff, overflow_in;
   logic                last_ff;
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_length_ff;
   logic                rsp_overflow_ff;
   logic                push;
   logic [SAMPLE_W-1:0] rd_data;

   assign push = cmd.accept && (items_ff != CNT_MAX);

   mwl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LEN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (req_sample_value),
      .rd_en   (cmd.pop_read),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      items_in    = items_ff;
      best_in     = best_ff;
      sum_in      = sum_ff;
      overflow_in = overflow_ff;
      if (cmd.accept) begin
         if (push) begin
            tail_in  = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
            count_in = count_ff + CNT_W'(1);
            items_in = items_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(req_sample_value);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.pop_read) begin
         if ((best_ff == '0) || (count_ff < best_ff)) begin
            best_in = count_ff;
         end
      end
      if (cmd.pop_apply) begin
         sum_in   = sum_ff - SUM_W'(rd_data);
         head_in  = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.emit) begin
         head_in     = '0;
         tail_in     = '0;
         count_in    = '0;
         items_in    = '0;
         best_in     = '0;
         sum_in      = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         items_ff     <= '0;
         best_ff      <= '0;
         sum_ff       <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         items_ff    <= items_in;
         best_ff     <= best_in;
         sum_ff      <= sum_in;
         overflow_ff <= overflow_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff <= req_is_last;
      end
      if (cmd.emit) begin
         rsp_length_ff   <= best_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign sts.qualify  = (count_ff != '0) && (CMP_W'(sum_ff) >= CMP_W'(target_ff));
   assign sts.last     = last_ff;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_shortest_length = rsp_length_ff;
   assign rsp_overflowed      = rsp_overflow_ff;

endmodule

// ===== src/min_window_length_sum_at_least_unit.sv =====
// An item is accepted, then checked against the target; while the window qualifies, the oldest
// sample is read from the window RAM and dropped, and a last item then loads the result register
// once the window settles. A new item is taken only after the previous one is through; each
// stored sample is written once and read at most once through the single window RAM.
// A waiting result holds off only the next last item, in its load cycle.
// Reset (synchronous): sequence state cleared, target_sum set to 1, RAM contents kept.
module min_window_length_sum_at_least_unit #(
   parameter int MAX_LEN = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mwl_pkg::SAMPLE_W-1:0]          req_sample_value,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [$clog2(MAX_LEN+1)-1:0]          rsp_shortest_length,
   output logic                                  rsp_overflowed,
   input  logic                                  csr_wr_en,
   input  logic [mwl_pkg::TARGET_W-1:0]          csr_wr_data
);
   import mwl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mwl_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_sample_value    (req_sample_value),
      .req_is_last         (req_is_last),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shortest_length (rsp_shortest_length),
      .rsp_overflowed      (rsp_overflowed)
   );

endmodule

// ===== test/shortest_window_checker.sv =====
module shortest_window_checker #(
   parameter int MAX_LEN = 1024,
   parameter int LEN_W = $clog2(MAX_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [mwl_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                          req_is_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [LEN_W-1:0]              rsp_shortest_length,
   input  logic                          rsp_overflowed,
   input  logic                          csr_wr_en,
   input  logic [mwl_pkg::TARGET_W-1:0]  csr_wr_data,
   output int                            outstanding,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LEN_W-1:0] shortest;
      logic             overflowed;
   } window_result_type;

   logic [mwl_pkg::SAMPLE_W-1:0] window_q[$];
   window_result_type            expected_q[$];
   logic [mwl_pkg::TARGET_W-1:0] target_sum;
   int unsigned                  window_sum;
   int unsigned                  best_len;
   int unsigned                  seen_count;
   logic                         overflow_seen;
   int                           mismatches = 0;

   function automatic void restart_window();
      window_q.delete();
      window_sum = 0;
      best_len = 0;
      seen_count = 0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void fold_sample(logic [mwl_pkg::SAMPLE_W-1:0] value, logic last);
      window_result_type res;
      if (seen_count < MAX_LEN) begin
         window_q.push_back(value);
         seen_count++;
         window_sum += value;
         while (window_q.size() > 0 && window_sum >= target_sum) begin
            if (best_len == 0 || window_q.size() < best_len)
               best_len = window_q.size();
            window_sum -= window_q.pop_front();
         end
      end else begin
         overflow_seen = 1'b1;
      end
      if (last) begin
         res.shortest = LEN_W'(best_len);
         res.overflowed = overflow_seen;
         expected_q.push_back(res);
         restart_window();
      end
   endfunction

   always @(posedge clock) begin : watch
      window_result_type oldest;
      if (reset) begin
         restart_window();
         target_sum = mwl_pkg::TARGET_RESET;
         expected_q.delete();
      end else begin
         if (csr_wr_en)
            target_sum = csr_wr_data;
         if (req_valid && !req_stall)
            fold_sample(req_sample_value, req_is_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got shortest_length %0d overflowed %0b",
                        $time, rsp_shortest_length, rsp_overflowed);
               mismatches++;
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_shortest_length !== oldest.shortest) begin
                  $display("%0t: shortest_length expected %0d got %0d",
                           $time, oldest.shortest, rsp_shortest_length);
                  mismatches++;
               end
               if (rsp_overflowed !== oldest.overflowed) begin
                  $display("%0t: overflowed expected %0b got %0b",
                           $time, oldest.overflowed, rsp_overflowed);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= expected_q.size();
      fail_count <= mismatches;
   end

endmodule

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN = 1024;
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int SAMPLE_W = mwl_pkg::SAMPLE_W;
   localparam int TARGET_W = mwl_pkg::TARGET_W;
   localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 60;
   localparam int PHASES = 8;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_value;
   logic                req_is_last;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [LEN_W-1:0]    rsp_shortest_length;
   logic                rsp_overflowed;
   logic                csr_wr_en;
   logic [TARGET_W-1:0] csr_wr_data;
   int                  outstanding;
   int                  fail_count;
   int                  quiet_cycles = 0;
   logic                no_gap_burst = 1'b0;
   logic                hold_go = 1'b0;
   logic                hold_done = 1'b0;

   always #10 clock = ~clock;

   min_window_length_sum_at_least_unit #(.MAX_LEN(MAX_LEN)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shortest_length (rsp_shortest_length),
      .rsp_overflowed      (rsp_overflowed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   shortest_window_checker #(.MAX_LEN(MAX_LEN)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shortest_length (rsp_shortest_length),
      .rsp_overflowed      (rsp_overflowed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .outstanding         (outstanding),
      .fail_count          (fail_count)
   );

   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gap_burst)
         return 0;
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample(int style);
      case (style)
         0: return SAMPLE_W'($urandom_range(0, 65535));
         1: return SAMPLE_W'($urandom_range(0, 255));
         2: return ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 65535)) : '0;
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return SAMPLE_W'(1);
               2: return {SAMPLE_W{1'b1}} - 1'b1;
               default: return {SAMPLE_W{1'b1}};
            endcase
         end
      endcase
   endfunction

   task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_sample_value <= value;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : receiver
      int roll;
      int stall_run;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         roll = $urandom_range(0, 99);
         if (hold_go && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (roll < 10) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(50, 300)) @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
               stall_run = 0;
            else if (roll < 93)
               stall_run = $urandom_range(1, 4);
            else
               stall_run = $urandom_range(10, 60);
            if (stall_run > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_run) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int phase;
      int sent;
      int len;
      int style;
      int roll;
      logic [TARGET_W-1:0] goal;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_value <= '0;
      req_is_last <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_beat('0, 1'b1);
      send_beat({SAMPLE_W{1'b1}}, 1'b1);
      send_beat('0, 1'b0);
      send_beat('0, 1'b0);
      send_beat(SAMPLE_W'(5), 1'b1);

      write_target('0);
      send_beat('0, 1'b0);
      send_beat('0, 1'b1);

      write_target(TARGET_MAX);
      send_beat({SAMPLE_W{1'b1}}, 1'b0);
      send_beat({SAMPLE_W{1'b1}}, 1'b1);

      write_target(TARGET_W'(65536));
      send_beat(SAMPLE_W'(1), 1'b0);
      send_beat('0, 1'b0);
      send_beat({SAMPLE_W{1'b1}}, 1'b1);
      send_beat({SAMPLE_W{1'b1}}, 1'b0);
      send_beat(SAMPLE_W'(1), 1'b1);

      write_target(TARGET_W'(100));
      send_beat(SAMPLE_W'(10), 1'b0);
      send_beat(SAMPLE_W'(20), 1'b0);
      send_beat(SAMPLE_W'(30), 1'b0);
      send_beat(SAMPLE_W'(40), 1'b0);
      send_beat(SAMPLE_W'(50), 1'b1);

      // full window only just reaches the target, last beat lands in the ignored tail
      write_target(TARGET_W'(MAX_LEN * 65535));
      no_gap_burst = 1'b1;
      for (int i = 0; i < MAX_LEN + 2; i++)
         send_beat({SAMPLE_W{1'b1}}, i == MAX_LEN + 1);
      no_gap_burst = 1'b0;
      send_beat(SAMPLE_W'(7), 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: goal = TARGET_W'(1);
            1: goal = TARGET_W'($urandom_range(2, 300));
            2: goal = TARGET_W'($urandom_range(300, 70000));
            3: goal = TARGET_W'($urandom_range(70000, 2000000));
            4: goal = TARGET_MAX;
            5: goal = TARGET_W'($urandom_range(1, 67108863));
            6: goal = TARGET_W'($urandom_range(100000, 500000));
            default: goal = TARGET_W'($urandom_range(1, 1000));
         endcase
         write_target(goal);
         if (phase == 1)
            hold_go = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS || (phase == 1 && !hold_done)) begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
               len = $urandom_range(1, 10);
            else if (roll < 95)
               len = $urandom_range(11, 60);
            else
               len = $urandom_range(61, 400);
            if (sent < PHASE_ITEMS && len > PHASE_ITEMS - sent)
               len = PHASE_ITEMS - sent;
            style = $urandom_range(0, 3);
            no_gap_burst = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
               send_beat(draw_sample(style), i == len - 1);
            sent += len;
         end
      end
      no_gap_burst = 1'b0;

      wait_idle();
      if (fail_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mwl_pkg.sv
src/mwl_ram.sv
src/mwl_ctrl.sv
src/mwl_datapath.sv
src/min_window_length_sum_at_least_unit.sv
test/shortest_window_checker.sv
test/testbench.sv
